// ===== src/rsenc_pkg.sv =====
// rsenc_pkg: shared types, constants and GF(256) arithmetic for the encoder
`default_nettype none

package rsenc_pkg;

   localparam int          BYTE_W   = 8;
   localparam int          CNT_W    = 6;
   localparam logic [7:0]  GF_POLY  = 8'h1d;  // x^8 + x^4 + x^3 + x^2 + 1, x^8 implied
   localparam logic [CNT_W-1:0] ECC_RESET = 6'd10;

   typedef logic [BYTE_W-1:0] byte_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_BUILD,
      CELL_ABSORB,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      byte_type    fb;
      byte_type    root;
   } cell_ctrl_type;

   function automatic byte_type gf_xtime(input byte_type a);
      gf_xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
   endfunction

   function automatic byte_type gf_mul(input byte_type a, input byte_type b);
      byte_type x;
      byte_type acc;
      x   = a;
      acc = '0;
      for (int k = 0; k < BYTE_W; k++) begin
         if (b[k]) begin
            acc = acc ^ x;
         end
         x = gf_xtime(x);
      end
      gf_mul = acc;
   endfunction

endpackage

`default_nettype wire

// ===== src/rsenc_cell.sv =====
// rsenc_cell: one stage of the encoder, one generator coefficient and one remainder byte
`default_nettype none

module rsenc_cell (
   input  wire logic                   clock,
   input  wire rsenc_pkg::cell_ctrl_type ctrl,
   input  wire rsenc_pkg::byte_type    g_prev,
   input  wire rsenc_pkg::byte_type    r_next,
   output rsenc_pkg::byte_type         g_out,
   output rsenc_pkg::byte_type         r_out
);

   rsenc_pkg::byte_type g_ff, g_in;
   rsenc_pkg::byte_type r_ff, r_in;
   rsenc_pkg::byte_type mul_a, mul_b, prod;

   // one multiplier shared between generator build and division
   always_comb begin
      if (ctrl.op == rsenc_pkg::CELL_BUILD) begin
         mul_a = g_prev;
         mul_b = ctrl.root;
      end else begin
         mul_a = ctrl.fb;
         mul_b = g_ff;
      end
      prod = rsenc_pkg::gf_mul(mul_a, mul_b);
   end

   always_comb begin
      g_in = g_ff;
      r_in = r_ff;
      case (ctrl.op)
         rsenc_pkg::CELL_HOLD: begin
         end
         rsenc_pkg::CELL_CLEAR: begin
            g_in = '0;
            r_in = '0;
         end
         rsenc_pkg::CELL_BUILD: begin
            g_in = g_ff ^ prod;
         end
         rsenc_pkg::CELL_ABSORB: begin
            r_in = r_next ^ prod;
         end
         rsenc_pkg::CELL_SHIFT: begin
            r_in = r_next;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      g_ff <= g_in;
      r_ff <= r_in;
   end

   assign g_out = g_ff;
   assign r_out = r_ff;

endmodule

`default_nettype wire

// ===== src/reed_solomon_gf256_encoder.sv =====
// reed_solomon_gf256_encoder: systematic RS encoder over GF(256) as a row of LFSR cells
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_data_byte, req_end_of_message
//   rsp      out        rsp_valid/rsp_ready  rsp_out_byte, rsp_is_parity,
//                                            rsp_end_of_codeword
//   csr      in         csr_valid/csr_ready  csr_ecc_count
//
// data bytes of a message are taken one per cycle unless rsp stalls; each echo waits in
// the output register. before the first byte of a message the cells are cleared and the
// generator is built, one root per cycle along the chain. n parity bytes end the codeword.
// reset leaves the block rebuilding for the reset parity count of 10.
// a stalled rsp side holds the output register and stops further requests.
`default_nettype none

module reed_solomon_gf256_encoder #(
   parameter int MAX_ECC = 63
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_end_of_message,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_is_parity,
   output logic            rsp_end_of_codeword,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [5:0] csr_ecc_count
);

   localparam logic [rsenc_pkg::CNT_W-1:0] MAX_N = rsenc_pkg::CNT_W'(MAX_ECC);

   typedef enum logic [1:0] {
      ST_START,
      ST_BUILD,
      ST_RUN,
      ST_PARITY
   } state_type;

   state_type state_ff, state_in;
   logic [rsenc_pkg::CNT_W-1:0] ecc_ff, ecc_in;
   logic [rsenc_pkg::CNT_W-1:0] n_ff, n_in;
   logic [rsenc_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                        first_ff, first_in;
   rsenc_pkg::byte_type         root_ff, root_in;
   logic                        out_valid_ff, out_valid_in;
   rsenc_pkg::byte_type         out_byte_ff, out_byte_in;
   logic                        out_par_ff, out_par_in;
   logic                        out_eoc_ff, out_eoc_in;

   logic [rsenc_pkg::CNT_W-1:0] eff_n;
   logic                        out_free, accept, csr_write;
   rsenc_pkg::cell_ctrl_type    ctrl;

   rsenc_pkg::byte_type g_chain [MAX_ECC];
   rsenc_pkg::byte_type r_chain [MAX_ECC];

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_RUN) && out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (ecc_ff == '0) begin
         eff_n = rsenc_pkg::CNT_W'(1);
      end else if (ecc_ff > MAX_N) begin
         eff_n = MAX_N;
      end else begin
         eff_n = ecc_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ecc_in       = csr_write ? csr_ecc_count : ecc_ff;
      n_in         = n_ff;
      cnt_in       = cnt_ff;
      first_in     = first_ff;
      root_in      = root_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_byte_in  = out_byte_ff;
      out_par_in   = out_par_ff;
      out_eoc_in   = out_eoc_ff;
      ctrl.op      = rsenc_pkg::CELL_HOLD;
      ctrl.fb      = req_data_byte ^ r_chain[0];
      ctrl.root    = root_ff;

      case (state_ff)
         ST_START: begin
            ctrl.op  = rsenc_pkg::CELL_CLEAR;
            n_in     = eff_n;
            cnt_in   = eff_n;
            root_in  = 8'h01;
            state_in = csr_write ? ST_START : ST_BUILD;
         end
         ST_BUILD: begin
            ctrl.op = rsenc_pkg::CELL_BUILD;
            root_in = rsenc_pkg::gf_xtime(root_ff);
            cnt_in  = cnt_ff - 1'b1;
            if (csr_write) begin
               state_in = ST_START;
            end else if (cnt_ff == rsenc_pkg::CNT_W'(1)) begin
               state_in = ST_RUN;
               first_in = 1'b1;
            end
         end
         ST_RUN: begin
            if (accept) begin
               ctrl.op      = rsenc_pkg::CELL_ABSORB;
               first_in     = 1'b0;
               out_valid_in = 1'b1;
               out_byte_in  = req_data_byte;
               out_par_in   = 1'b0;
               out_eoc_in   = 1'b0;
               if (req_end_of_message) begin
                  state_in = ST_PARITY;
                  cnt_in   = n_ff;
               end
            end else if (csr_write && first_ff) begin
               // count changed before the message began: rebuild
               state_in = ST_START;
            end
         end
         ST_PARITY: begin
            if (out_free) begin
               ctrl.op      = rsenc_pkg::CELL_SHIFT;
               out_valid_in = 1'b1;
               out_byte_in  = r_chain[0];
               out_par_in   = 1'b1;
               out_eoc_in   = (cnt_ff == rsenc_pkg::CNT_W'(1));
               cnt_in       = cnt_ff - 1'b1;
               if (cnt_ff == rsenc_pkg::CNT_W'(1)) begin
                  state_in = ST_START;
               end
            end
         end
         default: begin
            state_in = ST_START;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_START;
         ecc_ff       <= rsenc_pkg::ECC_RESET;
         n_ff         <= '0;
         cnt_ff       <= '0;
         first_ff     <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ecc_ff       <= ecc_in;
         n_ff         <= n_in;
         cnt_ff       <= cnt_in;
         first_ff     <= first_in;
         out_valid_ff <= out_valid_in;
      end
      root_ff     <= root_in;
      out_byte_ff <= out_byte_in;
      out_par_ff  <= out_par_in;
      out_eoc_ff  <= out_eoc_in;
   end

   // cell j holds remainder byte j and generator coefficient j+1
   for (genvar j = 0; j < MAX_ECC; j++) begin : g_cell
      rsenc_pkg::byte_type g_prev, r_next;
      if (j == 0) begin : g_head
         assign g_prev = 8'h01;
      end else begin : g_mid
         assign g_prev = g_chain[j-1];
      end
      if (j == MAX_ECC - 1) begin : g_tail
         assign r_next = '0;
      end else begin : g_body
         assign r_next = r_chain[j+1];
      end
      rsenc_cell u_cell (
         .clock  (clock),
         .ctrl   (ctrl),
         .g_prev (g_prev),
         .r_next (r_next),
         .g_out  (g_chain[j]),
         .r_out  (r_chain[j])
      );
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_out_byte        = out_byte_ff;
   assign rsp_is_parity       = out_par_ff;
   assign rsp_end_of_codeword = out_eoc_ff;

endmodule

`default_nettype wire

// ===== src/rsenc_checker.sv =====
// rsenc_checker: port-level checks on the encoder, bound to the top level
`default_nettype none

module rsenc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [7:0] req_data_byte,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_is_parity,
   input wire logic       rsp_end_of_codeword
);

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_is_parity) && $stable(rsp_end_of_codeword))
      else $error("stalled result changed");

   // the codeword ends on a parity byte
   a_eoc_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_codeword |-> rsp_is_parity)
      else $error("end of codeword on a data echo");

   // no request is taken while parity of the codeword is still to come
   a_no_req_in_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_parity && !rsp_end_of_codeword |-> !req_ready)
      else $error("request taken during parity");

   // an accepted request is echoed in the next cycle
   a_echo: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid && !rsp_is_parity
         && rsp_out_byte == $past(req_data_byte))
      else $error("data echo missing or wrong");

endmodule

bind reed_solomon_gf256_encoder rsenc_checker u_rsenc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .req_data_byte       (req_data_byte),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_out_byte        (rsp_out_byte),
   .rsp_is_parity       (rsp_is_parity),
   .rsp_end_of_codeword (rsp_end_of_codeword)
);

`default_nettype wire
